// File: src/assert_macros.svh
// Assertion macros used by the interrupt controller RTL.
// No dependencies; pulled in by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: src/ic_ime_pkg.sv
// Types and constants of the interrupt controller (enable, flags, master enable).
// No dependencies; imported by every module of the block.
package ic_ime_pkg;

  typedef enum logic [1:0] {
    REQ_RAISE = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_TICK  = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    TGT_ENABLE = 2'd0,
    TGT_FLAGS  = 2'd1,
    TGT_MASTER = 2'd2
  } target_e_t;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned SRC_W  = 14;

  localparam logic [DATA_W-1:0] PEND_MASK = 16'h03FF;
  localparam logic [7:0]        BYTE_MASK = 8'hFF;

  typedef struct packed {
    req_e_t            req_type;
    target_e_t         target;
    logic              byte_wide;
    logic              byte_sel;
    logic [DATA_W-1:0] write_data;
    logic [SRC_W-1:0]  source_mask;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              irq_line;
  } res_t;

  typedef struct packed {
    logic master_enable;
    logic line_out;
    logic pending;
  } status_t;

endpackage

// File: src/ic_ime_in_stage.sv
// Input register of the interrupt controller: unpacks and holds one item.
// Depends on ic_ime_pkg.
module ic_ime_in_stage
  import ic_ime_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [5:0]  s_tuser,
  input  logic        take,
  output logic        valid,
  output in_item_t    item
);

  assign s_tready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.req_type    <= req_e_t'(s_tuser[1:0]);
      item.target      <= target_e_t'(s_tuser[3:2]);
      item.byte_wide   <= s_tuser[4];
      item.byte_sel    <= s_tuser[5];
      item.write_data  <= s_tdata[15:0];
      item.source_mask <= s_tdata[29:16];
    end
  end

endmodule

// File: src/ic_ime_regs.sv
// Register file and line logic of the interrupt controller.
// Depends on ic_ime_pkg.
module ic_ime_regs
  import ic_ime_pkg::*;
#(
  parameter int unsigned UPDATE_DELAY = 3
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_item_t item,
  output res_t     result,
  output status_t  status
);

  localparam logic [UPDATE_DELAY-1:0] TOP_SLOT =
    UPDATE_DELAY'(1) << (UPDATE_DELAY - 1);

  logic [DATA_W-1:0]       enable_bits, enable_bits_next;
  logic [DATA_W-1:0]       flag_bits, flag_bits_next;
  logic                    master_enable, master_enable_next;
  logic                    line_out, line_out_next;
  logic [UPDATE_DELAY-1:0] pending_updates, pending_updates_next;

  logic              pending;
  logic              changed;
  logic              me_hit;
  logic [DATA_W-1:0] clr_mask;
  logic [DATA_W-1:0] rd_word;
  logic [DATA_W-1:0] rd;

  assign pending = |(enable_bits & flag_bits & PEND_MASK);
  assign me_hit  = !item.byte_wide || !item.byte_sel;

  always_comb begin
    if (!item.byte_wide) begin
      clr_mask = item.write_data;
    end else if (item.byte_sel) begin
      clr_mask = {item.write_data[7:0] & BYTE_MASK, 8'h00};
    end else begin
      clr_mask = {8'h00, item.write_data[7:0] & BYTE_MASK};
    end
  end

  always_comb begin
    case (item.target)
      TGT_ENABLE: rd_word = enable_bits;
      TGT_FLAGS:  rd_word = flag_bits;
      TGT_MASTER: rd_word = {{(DATA_W-1){1'b0}}, master_enable};
      default:    rd_word = '0;
    endcase
    if (!item.byte_wide) begin
      rd = rd_word;
    end else if (item.byte_sel) begin
      rd = {8'h00, rd_word[15:8]};
    end else begin
      rd = {8'h00, rd_word[7:0]};
    end
  end

  always_comb begin
    enable_bits_next     = enable_bits;
    flag_bits_next       = flag_bits;
    master_enable_next   = master_enable;
    line_out_next        = line_out;
    pending_updates_next = pending_updates;
    changed              = 1'b0;
    case (item.req_type)
      REQ_RAISE: begin
        flag_bits_next = flag_bits | {2'b00, item.source_mask};
        changed        = 1'b1;
      end
      REQ_WRITE: begin
        case (item.target)
          TGT_ENABLE: begin
            changed = 1'b1;
            if (!item.byte_wide) begin
              enable_bits_next = item.write_data;
            end else if (item.byte_sel) begin
              enable_bits_next = {item.write_data[7:0], enable_bits[7:0]};
            end else begin
              enable_bits_next = {enable_bits[15:8], item.write_data[7:0]};
            end
          end
          TGT_FLAGS: begin
            changed        = 1'b1;
            flag_bits_next = flag_bits & ~clr_mask;
          end
          TGT_MASTER: begin
            if (me_hit && (item.write_data[0] != master_enable)) begin
              master_enable_next = item.write_data[0];
              line_out_next      = item.write_data[0] && pending;
            end
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        if (pending_updates[0]) begin
          line_out_next = pending;
        end
        pending_updates_next = pending_updates >> 1;
      end
      default: ;
    endcase
    // schedule a delayed line update while the master enable is set
    if (changed && master_enable) begin
      pending_updates_next = pending_updates | TOP_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_bits     <= '0;
      flag_bits       <= '0;
      master_enable   <= 1'b0;
      line_out        <= 1'b0;
      pending_updates <= '0;
    end else if (fire) begin
      enable_bits     <= enable_bits_next;
      flag_bits       <= flag_bits_next;
      master_enable   <= master_enable_next;
      line_out        <= line_out_next;
      pending_updates <= pending_updates_next;
    end
  end

  assign result.read_data = (item.req_type == REQ_READ) ? rd : '0;
  assign result.irq_line  = line_out_next;

  assign status.master_enable = master_enable;
  assign status.line_out      = line_out;
  assign status.pending       = pending;

endmodule

// File: src/ic_ime_out_stage.sv
// Result register of the interrupt controller: holds one result for the sink.
// Depends on ic_ime_pkg.
module ic_ime_out_stage
  import ic_ime_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_t        result,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata
);

  res_t hold;

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      hold <= result;
    end
  end

  assign m_tdata = {7'd0, hold.irq_line, hold.read_data};

endmodule

// File: src/interrupt_controller_ie_if_ime_unit.sv
// Top level of the interrupt controller with enable, flag and master enable registers.
// Depends on ic_ime_pkg, ic_ime_in_stage, ic_ime_regs, ic_ime_out_stage, assert_macros.svh.
//
// Each input item is one request: raise sources (OR into the flags), write a
// register, read a register, or one clock tick. Registers are addressed by
// target: enable, flags (writing 1 clears a bit), master enable (bit 0).
// Byte accesses address one byte of the halfword. The pending condition is
// enable & flags & 0x3FF. While the master enable is set, a raise or a write
// to enable or flags schedules a line update that fires on the UPDATE_DELAY-th
// tick after it and drives the line to the pending condition of that moment.
// Setting the master enable drives the line to the pending condition at once,
// clearing it drops the line at once. Every item gives exactly one result:
// read data (zero unless a read) and the line after the request.
// Timing: one item per cycle while the master side takes results; an
// accepted item goes into the input register, then its result into the
// result register, from which it is offered on the master side, with
// all register updates done in the single logic step between them.
// Backpressure on the master side stalls the input register only once the
// result register is full.
module interrupt_controller_ie_if_ime_unit
  import ic_ime_pkg::*;
#(
  parameter int unsigned UPDATE_DELAY = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] write_data, [29:16] source_mask, [31:30] zero
  input  logic [31:0] s_tdata,
  // [1:0] req_type, [3:2] target, [4] byte_wide, [5] byte_sel
  input  logic [5:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] read_data, [16] irq_line, [23:17] zero
  output logic [23:0] m_tdata
);

  `include "assert_macros.svh"

  logic     in_valid;
  logic     out_free;
  logic     fire;
  in_item_t item;
  res_t     result;
  status_t  status;

  // move the held item into the result register when it has room
  assign fire = in_valid && out_free;

  ic_ime_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (out_free),
    .valid    (in_valid),
    .item     (item)
  );

  ic_ime_regs #(
    .UPDATE_DELAY (UPDATE_DELAY)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result),
    .status (status)
  );

  ic_ime_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (in_valid),
    .result   (result),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // an item handed to the result register is offered on the next cycle
  `ASSERT_CLK(a_fire_shows, clk, rst, fire |=> m_tvalid, "result lost after handoff")
  // the line changes only when an item is handled
  `ASSERT_CLK(a_line_moves, clk, rst, !$stable(status.line_out) |-> $past(fire), "line changed without an item")
  // clearing the master enable drops the line in the same step
  `ASSERT_CLK(a_me_off, clk, rst, $fell(status.master_enable) |-> !status.line_out, "line high after master enable cleared")
  // setting the master enable takes the pending condition at once
  `ASSERT_CLK(a_me_on, clk, rst, $rose(status.master_enable) |-> (status.line_out == status.pending), "line not pending on master enable")

endmodule

// File: bench/tb_interrupt_controller_ie_if_ime_unit.sv
// Self-checking bench for interrupt_controller_ie_if_ime_unit: a directed table,
// then random requests, each result checked against a built-in predictor or a typed-in value.
// Depends on ic_ime_pkg and the RTL of the block; reads no files.
module tb_interrupt_controller_ie_if_ime_unit;
  import ic_ime_pkg::*;

  localparam int UPD_DELAY   = 3;
  localparam int RAND_ITEMS  = 1630;
  localparam int DRAIN_EVERY = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SHOW_MAX    = 10;

  // Register index with no register behind it.
  localparam logic [1:0] TGT_NONE = 2'd3;

  // One request as the bench sees it; target is kept raw so TGT_NONE fits.
  typedef struct packed {
    req_e_t      req_type;
    logic [1:0]  target;
    logic        byte_wide;
    logic        byte_sel;
    logic [15:0] write_data;
    logic [13:0] source_mask;
  } ic_req_t;

  // Directed row: the request and, where obvious, the result typed in.
  typedef struct packed {
    req_e_t      req;
    logic [1:0]  tgt;
    logic        bw;
    logic        bi;
    logic [15:0] wd;
    logic [13:0] sm;
    logic        typed;
    logic [15:0] rd;
    logic        irq;
  } dir_row_t;

  localparam int DIR_ROWS = 26;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // Reset values read back as zero, line low.
    '{REQ_READ,  TGT_ENABLE, 1'b0, 1'b0, 16'h0000, 14'h0000, 1'b1, 16'h0000, 1'b0},
    '{REQ_READ,  TGT_FLAGS,  1'b0, 1'b0, 16'h0000, 14'h0000, 1'b1, 16'h0000, 1'b0},
    '{REQ_READ,  TGT_MASTER, 1'b0, 1'b0, 16'h0000, 14'h0000, 1'b1, 16'h0000, 1'b0},
    // Raise every source with the master enable off: flags set, line stays low.
    '{REQ_RAISE, TGT_ENABLE, 1'b0, 1'b0, 16'h0000, 14'h3FFF, 1'b1, 16'h0000, 1'b0},
    '{REQ_READ,  TGT_FLAGS,  1'b0, 1'b0, 16'h0000, 14'h0000, 1'b1, 16'h3FFF, 1'b0},
    '{REQ_WRITE, TGT_ENABLE, 1'b0, 1'b0, 16'hFFFF, 14'h0000, 1'b1, 16'h0000, 1'b0},
    // Master enable: only bit 0 counts, a write to byte 1 does nothing.
    '{REQ_WRITE, TGT_MASTER, 1'b0, 1'b0, 16'hFFFE, 14'h0000, 1'b1, 16'h0000, 1'b0},
    '{REQ_WRITE, TGT_MASTER, 1'b1, 1'b1, 16'h0001, 14'h0000, 1'b1, 16'h0000, 1'b0},
    // Setting it takes the pending condition at once.
    '{REQ_WRITE, TGT_MASTER, 1'b1, 1'b0, 16'h0001, 14'h0000, 1'b1, 16'h0000, 1'b1},
    '{REQ_READ,  TGT_MASTER, 1'b1, 1'b1, 16'h0000, 14'h0000, 1'b1, 16'h0000, 1'b1},
    '{REQ_READ,  TGT_MASTER, 1'b0, 1'b0, 16'h0000, 14'h0000, 1'b1, 16'h0001, 1'b1},
    // Clear every flag: the line follows only after the update delay.
    '{REQ_WRITE, TGT_FLAGS,  1'b0, 1'b0, 16'hFFFF, 14'h0000, 1'b1, 16'h0000, 1'b1},
    '{REQ_TICK,  TGT_ENABLE, 1'b0, 1'b0, 16'h0000, 14'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_TICK,  TGT_ENABLE, 1'b0, 1'b0, 16'h0000, 14'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_TICK,  TGT_ENABLE, 1'b0, 1'b0, 16'h0000, 14'h0000, 1'b0, 16'h0000, 1'b0},
    // Raise and byte flag clear on the same tick merge into one update.
    '{REQ_RAISE, TGT_ENABLE, 1'b0, 1'b0, 16'h0000, 14'h0300, 1'b0, 16'h0000, 1'b0},
    '{REQ_WRITE, TGT_FLAGS,  1'b1, 1'b1, 16'h0001, 14'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_READ,  TGT_FLAGS,  1'b1, 1'b1, 16'h0000, 14'h0000, 1'b0, 16'h0000, 1'b0},
    // Drop the master enable; the scheduled update still fires.
    '{REQ_WRITE, TGT_MASTER, 1'b0, 1'b0, 16'h0000, 14'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_TICK,  TGT_ENABLE, 1'b0, 1'b0, 16'h0000, 14'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_TICK,  TGT_ENABLE, 1'b0, 1'b0, 16'h0000, 14'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_TICK,  TGT_ENABLE, 1'b0, 1'b0, 16'h0000, 14'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_WRITE, TGT_ENABLE, 1'b1, 1'b1, 16'h00AB, 14'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_READ,  TGT_ENABLE, 1'b1, 1'b1, 16'h0000, 14'h0000, 1'b0, 16'h0000, 1'b0},
    // The unused register index: write ignored, read gives zero.
    '{REQ_WRITE, TGT_NONE,   1'b0, 1'b0, 16'hFFFF, 14'h0000, 1'b0, 16'h0000, 1'b0},
    '{REQ_READ,  TGT_NONE,   1'b0, 1'b0, 16'h0000, 14'h0000, 1'b0, 16'h0000, 1'b0}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [5:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  interrupt_controller_ie_if_ime_unit #(
    .UPDATE_DELAY(UPD_DELAY)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #6 clk = ~clk;

  // Predictor state: enable, flags, master enable, line, scheduled updates.
  logic [15:0]          ie_reg    = '0;
  logic [15:0]          if_reg    = '0;
  logic                 ime_reg   = 1'b0;
  logic                 irq_reg   = 1'b0;
  logic [UPD_DELAY-1:0] upd_slots = '0;

  res_t predicted_q [$];
  int   errors  = 0;
  int   cycles  = 0;
  int   rx_hold = 0;
  int   rx_gap;
  logic rx_quiet;
  logic tx_quiet = 1'b0;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic irq_cond();
    return |(ie_reg & if_reg & PEND_MASK);
  endfunction

  // Advance the predictor by one request and give the result it causes.
  task automatic irq_predict(input ic_req_t it, output res_t r);
    logic [15:0] v;
    r = '0;
    case (it.req_type)
      REQ_RAISE: begin
        if_reg = if_reg | {2'b00, it.source_mask};
        if (ime_reg) upd_slots[UPD_DELAY-1] = 1'b1;
      end
      REQ_WRITE: begin
        if (it.target == TGT_ENABLE) begin
          if (!it.byte_wide) ie_reg = it.write_data;
          else if (it.byte_sel) ie_reg[15:8] = it.write_data[7:0];
          else ie_reg[7:0] = it.write_data[7:0];
          if (ime_reg) upd_slots[UPD_DELAY-1] = 1'b1;
        end else if (it.target == TGT_FLAGS) begin
          // Writing 1 clears; a byte write touches its own byte only.
          if (!it.byte_wide) if_reg = if_reg & ~it.write_data;
          else if (it.byte_sel) if_reg[15:8] = if_reg[15:8] & ~it.write_data[7:0];
          else if_reg[7:0] = if_reg[7:0] & ~it.write_data[7:0];
          if (ime_reg) upd_slots[UPD_DELAY-1] = 1'b1;
        end else if (it.target == TGT_MASTER) begin
          if ((!it.byte_wide || !it.byte_sel) && it.write_data[0] != ime_reg) begin
            ime_reg = it.write_data[0];
            irq_reg = ime_reg ? irq_cond() : 1'b0;
          end
        end
      end
      REQ_READ: begin
        if (it.target == TGT_ENABLE) v = ie_reg;
        else if (it.target == TGT_FLAGS) v = if_reg;
        else if (it.target == TGT_MASTER) v = {15'd0, ime_reg};
        else v = '0;
        if (!it.byte_wide) r.read_data = v;
        else r.read_data = it.byte_sel ? {8'h00, v[15:8]} : {8'h00, v[7:0]};
      end
      default: begin
        // Tick: fire the oldest slot, then move the rest one step closer.
        if (upd_slots[0]) irq_reg = irq_cond();
        upd_slots = upd_slots >> 1;
      end
    endcase
    r.irq_line = irq_reg;
  endtask

  // Offer one item, hold it until accepted, then queue its expected result.
  // A typed-in result, where given, takes the place of the predicted one.
  task automatic send_req(input ic_req_t it, input logic typed, input res_t want);
    int   gap;
    res_t r;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, it.source_mask, it.write_data};
    s_tuser  <= {it.byte_sel, it.byte_wide, it.target, it.req_type};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    irq_predict(it, r);
    predicted_q.push_back(typed ? want : r);
  endtask

  // Hold the sender off until every queued result has come back.
  task automatic wait_empty();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_word();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'h0000;
    if (k == 1) return 16'hFFFF;
    if (k < 5) return 16'h0001 << $urandom_range(0, 15);
    return 16'($urandom);
  endfunction

  function automatic logic [13:0] rand_sources();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 14'h0000;
    if (k == 1) return 14'h3FFF;
    if (k < 6) return 14'h0001 << $urandom_range(0, 13);
    return 14'($urandom);
  endfunction

  // Random request, weighted toward writes and ticks so updates fire often.
  function automatic ic_req_t rand_req();
    ic_req_t it;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 20) it.req_type = REQ_RAISE;
    else if (r < 50) it.req_type = REQ_WRITE;
    else if (r < 70) it.req_type = REQ_READ;
    else it.req_type = REQ_TICK;
    if ($urandom_range(0, 99) < 3) it.target = TGT_NONE;
    else it.target = 2'($urandom_range(0, 2));
    it.byte_wide   = 1'($urandom_range(0, 1));
    it.byte_sel    = 1'($urandom_range(0, 1));
    it.write_data  = rand_word();
    it.source_mask = rand_sources();
    return it;
  endfunction

  // Sink side: check each accepted result, then pick the next stall.
  always @(posedge clk) begin
    rx_quiet = ((cycles / 400) % 5) == 2;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_q.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("result with nothing expected: read_data=%h irq_line=%b",
                   m_tdata[15:0], m_tdata[16]);
      end else begin
        if (m_tdata[15:0] !== predicted_q[0].read_data ||
            m_tdata[16] !== predicted_q[0].irq_line) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("mismatch: read_data exp %h got %h, irq_line exp %b got %b",
                     predicted_q[0].read_data, m_tdata[15:0],
                     predicted_q[0].irq_line, m_tdata[16]);
        end
        void'(predicted_q.pop_front());
      end
    end
    if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else begin
      rx_gap = rx_quiet ? 0 : pick_gap();
      if (rx_gap > 0) begin
        rx_hold  <= rx_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    ic_req_t it;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table first.
    for (int i = 0; i < DIR_ROWS; i++) begin
      it.req_type    = dir_rows[i].req;
      it.target      = dir_rows[i].tgt;
      it.byte_wide   = dir_rows[i].bw;
      it.byte_sel    = dir_rows[i].bi;
      it.write_data  = dir_rows[i].wd;
      it.source_mask = dir_rows[i].sm;
      send_req(it, dir_rows[i].typed, '{dir_rows[i].rd, dir_rows[i].irq});
    end

    // Random part, with stretches of back-to-back items and periodic drains.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      tx_quiet = ((i / 150) % 4) == 1;
      if (i > 0 && i % DRAIN_EVERY == 0) wait_empty();
      send_req(rand_req(), 1'b0, '0);
    end

    s_tvalid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    // Let any stray result show up before judging.
    repeat (10) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
